// ----- sv/bpc_pkg.sv -----
// bpc_pkg: types, constants and helpers for the barometric compensation unit
// used by bpc_div and barometric_pressure_compensation_unit; no dependencies
`timescale 1ns / 1ps

package bpc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_OSS    = 3'd0;
    localparam logic [2:0] REG_AC1AC2 = 3'd1;
    localparam logic [2:0] REG_AC3AC4 = 3'd2;
    localparam logic [2:0] REG_AC5AC6 = 3'd3;
    localparam logic [2:0] REG_B1B2   = 3'd4;
    localparam logic [2:0] REG_MCMD   = 3'd5;

    // divider geometry: temperature divides a 27-bit magnitude by 32 bits,
    // pressure divides 32 bits by the 17-bit b4
    localparam int T_DW = 27;
    localparam int T_VW = 32;
    localparam int P_DW = 32;
    localparam int P_VW = 17;

    localparam logic [31:0] C_B6_OFFSET = 32'd4000;
    localparam logic [31:0] C_B4_BIAS   = 32'd32768;
    localparam logic [31:0] C_OSS_BASE  = 32'd50000;
    localparam logic [31:0] C_P_MUL     = 32'd3038;
    localparam logic [31:0] C_P_NEG     = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_ADD     = 32'd3791;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TDIV  = 2'd1,
        ST_PDIV  = 2'd2,
        ST_DELTA = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] uncomp_pressure;
    } req_t;

    typedef struct packed {
        logic signed [31:0] temperature_tenths;
        logic signed [31:0] pressure_pascal;
        logic [1:0]         status;
    } res_t;

    typedef struct packed {
        logic [31:0] x1;
        logic [18:0] up;
        logic        neg;
        logic        dzero;
    } d1_side_t;

    typedef struct packed {
        logic [31:0] temp;
        status_t     status;
        logic        shift;
    } d2_side_t;

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        return $unsigned($signed(v) >>> n);
    endfunction

endpackage

// ----- sv/bpc_div.sv -----
// bpc_div: pipelined unsigned restoring divider, one quotient bit per stage
// sideband data travels alongside; depends on bpc_pkg for default widths
`timescale 1ns / 1ps

module bpc_div #(
    parameter int DW = bpc_pkg::P_DW,
    parameter int VW = bpc_pkg::P_VW,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [DW-1:0] quotient,
    output logic [SW-1:0] side_out
);

    logic          vld_reg  [0:DW-1];
    logic [DW-1:0] num_reg  [0:DW-1];
    logic [VW-1:0] rem_reg  [0:DW-1];
    logic [VW-1:0] dvs_reg  [0:DW-1];
    logic [SW-1:0] side_reg [0:DW-1];

    for (genvar g = 0; g < DW; g++)
    begin : g_stage
        logic          cv;
        logic [DW-1:0] cn;
        logic [VW-1:0] cr;
        logic [VW-1:0] cd;
        logic [SW-1:0] cs;
        logic [VW:0]   trial;
        logic [VW:0]   diff;
        logic          ge;

        if (g == 0)
        begin : g_first
            assign cv = in_valid;
            assign cn = dividend;
            assign cr = '0;
            assign cd = divisor;
            assign cs = side_in;
        end
        else
        begin : g_rest
            assign cv = vld_reg[g-1];
            assign cn = num_reg[g-1];
            assign cr = rem_reg[g-1];
            assign cd = dvs_reg[g-1];
            assign cs = side_reg[g-1];
        end

        assign trial = {cr, cn[DW-1]};
        assign diff  = trial - {1'b0, cd};
        assign ge    = (trial >= {1'b0, cd});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else
            begin
                vld_reg[g] <= cv;
            end
        end

        // quotient bits shift in from the bottom as dividend bits leave the top
        always_ff @(posedge clk)
        begin
            num_reg[g]  <= {cn[DW-2:0], ge};
            rem_reg[g]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
            dvs_reg[g]  <= cd;
            side_reg[g] <= cs;
        end
    end

    assign out_valid = vld_reg[DW-1];
    assign quotient  = num_reg[DW-1];
    assign side_out  = side_reg[DW-1];

endmodule

// ----- sv/barometric_pressure_compensation_unit.sv -----
// barometric_pressure_compensation_unit: top level of the compensation pipeline
// depends on bpc_pkg and bpc_div
`timescale 1ns / 1ps

// Takes one request (raw temperature and raw pressure) in every clock cycle;
// busy is always low. Each result appears on result for exactly one cycle,
// marked by done, in request order; the receiver cannot hold results off, so
// it must take each one as it comes. The pipeline has 73 register stages:
// the two dividers, 27 stages for the temperature quotient and 32 for the
// pressure quotient, each resolving one bit per stage, plus 14 arithmetic
// stages. Configuration must only be written while no request is in flight;
// the write channel is always ready.
module barometric_pressure_compensation_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bpc_pkg::req_t request,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output logic          done,
    output bpc_pkg::res_t result
);

    import bpc_pkg::*;

    localparam int LATENCY = 2 + T_DW + 8 + P_DW + 4;

    logic [1:0]  oss_reg;
    logic [31:0] cal_reg [0:4];

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    assign ac1 = {{16{cal_reg[0][31]}}, cal_reg[0][31:16]};
    assign ac2 = {{16{cal_reg[0][15]}}, cal_reg[0][15:0]};
    assign ac3 = {{16{cal_reg[1][31]}}, cal_reg[1][31:16]};
    assign ac4 = {16'b0, cal_reg[1][15:0]};
    assign ac5 = {16'b0, cal_reg[2][31:16]};
    assign ac6 = {16'b0, cal_reg[2][15:0]};
    assign b1  = {{16{cal_reg[3][31]}}, cal_reg[3][31:16]};
    assign b2  = {{16{cal_reg[3][15]}}, cal_reg[3][15:0]};
    assign mc  = {{16{cal_reg[4][31]}}, cal_reg[4][31:16]};
    assign md  = {{16{cal_reg[4][15]}}, cal_reg[4][15:0]};

    logic accept;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg <= '0;
            for (int i = 0; i < 5; i++)
            begin
                cal_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OSS:    oss_reg    <= cfg_data[1:0];
                REG_AC1AC2: cal_reg[0] <= cfg_data;
                REG_AC3AC4: cal_reg[1] <= cfg_data;
                REG_AC5AC6: cal_reg[2] <= cfg_data;
                REG_B1B2:   cal_reg[3] <= cfg_data;
                REG_MCMD:   cal_reg[4] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ---------------- stage registers ----------------
    logic v1_reg, v2_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic v10_reg, v11_reg, v13_reg, v14_reg, v15_reg, done_reg;

    logic [31:0] p1_reg, x1_2_reg, den2_reg;
    logic [18:0] up1_reg, up2_reg, up4_reg, up5_reg, up6_reg, up7_reg, up8_reg, up9_reg;
    logic [31:0] x1_4_reg, x2_4_reg;
    logic        dz4_reg, dz5_reg, dz6_reg, dz7_reg, dz8_reg, dz9_reg, dz10_reg;
    logic [31:0] temp5_reg, temp6_reg, temp7_reg, temp8_reg, temp9_reg, temp10_reg;
    logic [31:0] temp11_reg, temp13_reg, temp14_reg, temp15_reg;
    logic [31:0] b6_5_reg, sq6_reg, a2_6_reg, a3_6_reg;
    logic [31:0] b6sq7_reg, x2a7_reg, x1c7_reg;
    logic [31:0] pb2_8_reg, pb1_8_reg, x2a8_reg, x1c8_reg;
    logic [31:0] b3_9_reg, x3b_9_reg;
    logic [31:0] pb4_10_reg, delta10_reg;
    logic [16:0] b4_11_reg;
    logic [31:0] b7_11_reg;
    status_t     st11_reg, st13_reg, st14_reg, st15_reg;
    logic [31:0] pres13_reg, pres14_reg, pres15_reg;
    logic [31:0] m1_14_reg, m2_14_reg, m3_15_reg, x2_15_reg;
    res_t        res_reg;

    // ---------------- temperature divider ----------------
    logic [31:0] mc_sh;
    logic [T_DW-1:0] t_num;
    logic [T_VW-1:0] t_dvs;
    logic [31:0]     mc_neg, den_neg;
    d1_side_t        d1_in, d1_out;
    logic            d1_valid;
    logic [T_DW-1:0] t_quo;

    assign mc_sh   = mc << 11;
    assign mc_neg  = 32'd0 - mc_sh;
    assign den_neg = 32'd0 - den2_reg;
    assign t_num   = mc_sh[31] ? mc_neg[T_DW-1:0] : mc_sh[T_DW-1:0];
    assign t_dvs   = den2_reg[31] ? den_neg : den2_reg;
    assign d1_in   = '{x1: x1_2_reg, up: up2_reg, neg: mc_sh[31] ^ den2_reg[31],
                       dzero: (den2_reg == 32'd0)};

    bpc_div #(
        .DW (T_DW),
        .VW (T_VW),
        .SW ($bits(d1_side_t))
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .dividend  (t_num),
        .divisor   (t_dvs),
        .side_in   (d1_in),
        .out_valid (d1_valid),
        .quotient  (t_quo),
        .side_out  (d1_out)
    );

    // ---------------- pressure divider ----------------
    logic [P_DW-1:0] p_num;
    d2_side_t        d2_in, d2_out;
    logic            d2_valid;
    logic [P_DW-1:0] p_quo;

    // large b7 is divided first and doubled after, as the shift would overflow
    assign p_num = b7_11_reg[31] ? b7_11_reg : (b7_11_reg << 1);
    assign d2_in = '{temp: temp11_reg, status: st11_reg, shift: b7_11_reg[31]};

    bpc_div #(
        .DW (P_DW),
        .VW (P_VW),
        .SW ($bits(d2_side_t))
    ) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v11_reg),
        .dividend  (p_num),
        .divisor   (b4_11_reg),
        .side_in   (d2_in),
        .out_valid (d2_valid),
        .quotient  (p_quo),
        .side_out  (d2_out)
    );

    // ---------------- combinational helpers ----------------
    logic [31:0] x1_2_next, b5, x3_9, pres13_x1, p_final;
    logic [16:0] b4_next;

    assign x1_2_next = asr(p1_reg, 15);
    assign b5        = x1_4_reg + x2_4_reg;
    assign x3_9      = asr(pb2_8_reg, 11) + x2a8_reg;
    assign b4_next   = pb4_10_reg[31:15];
    assign pres13_x1 = asr(pres13_reg, 8);
    assign p_final   = pres15_reg + asr(asr(m3_15_reg, 16) + x2_15_reg + C_P_ADD, 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            v11_reg  <= 1'b0;
            v13_reg  <= 1'b0;
            v14_reg  <= 1'b0;
            v15_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v4_reg   <= d1_valid;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            v10_reg  <= v9_reg;
            v11_reg  <= v10_reg;
            v13_reg  <= d2_valid;
            v14_reg  <= v13_reg;
            v15_reg  <= v14_reg;
            done_reg <= v15_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // x1 product and pressure capture
        p1_reg  <= ({16'b0, request.raw_temperature} - ac6) * ac5;
        up1_reg <= request.uncomp_pressure;

        x1_2_reg <= x1_2_next;
        den2_reg <= x1_2_next + md;
        up2_reg  <= up1_reg;

        // signed quotient restored from magnitudes, truncating toward zero
        x2_4_reg <= d1_out.neg ? (32'd0 - {{(32 - T_DW){1'b0}}, t_quo})
                               : {{(32 - T_DW){1'b0}}, t_quo};
        x1_4_reg <= d1_out.x1;
        up4_reg  <= d1_out.up;
        dz4_reg  <= d1_out.dzero;

        temp5_reg <= asr(b5 + 32'd8, 4);
        b6_5_reg  <= b5 - C_B6_OFFSET;
        up5_reg   <= up4_reg;
        dz5_reg   <= dz4_reg;

        sq6_reg   <= b6_5_reg * b6_5_reg;
        a2_6_reg  <= ac2 * b6_5_reg;
        a3_6_reg  <= ac3 * b6_5_reg;
        temp6_reg <= temp5_reg;
        up6_reg   <= up5_reg;
        dz6_reg   <= dz5_reg;

        b6sq7_reg <= asr(sq6_reg, 12);
        x2a7_reg  <= asr(a2_6_reg, 11);
        x1c7_reg  <= asr(a3_6_reg, 13);
        temp7_reg <= temp6_reg;
        up7_reg   <= up6_reg;
        dz7_reg   <= dz6_reg;

        pb2_8_reg <= b2 * b6sq7_reg;
        pb1_8_reg <= b1 * b6sq7_reg;
        x2a8_reg  <= x2a7_reg;
        x1c8_reg  <= x1c7_reg;
        temp8_reg <= temp7_reg;
        up8_reg   <= up7_reg;
        dz8_reg   <= dz7_reg;

        b3_9_reg  <= asr((((ac1 << 2) + x3_9) << oss_reg) + 32'd2, 2);
        x3b_9_reg <= asr(x1c8_reg + asr(pb1_8_reg, 16) + 32'd2, 2);
        temp9_reg <= temp8_reg;
        up9_reg   <= up8_reg;
        dz9_reg   <= dz8_reg;

        pb4_10_reg  <= ac4 * (x3b_9_reg + C_B4_BIAS);
        delta10_reg <= {13'b0, up9_reg} - b3_9_reg;
        temp10_reg  <= temp9_reg;
        dz10_reg    <= dz9_reg;

        // first failing check wins
        b4_11_reg  <= b4_next;
        b7_11_reg  <= delta10_reg * (C_OSS_BASE >> oss_reg);
        temp11_reg <= temp10_reg;
        if (dz10_reg)
        begin
            st11_reg <= ST_TDIV;
        end
        else if (b4_next == '0)
        begin
            st11_reg <= ST_PDIV;
        end
        else if ((delta10_reg == 32'd0) || delta10_reg[31])
        begin
            st11_reg <= ST_DELTA;
        end
        else
        begin
            st11_reg <= ST_OK;
        end

        pres13_reg <= d2_out.shift ? (p_quo << 1) : p_quo;
        temp13_reg <= d2_out.temp;
        st13_reg   <= d2_out.status;

        m1_14_reg  <= pres13_x1 * pres13_x1;
        m2_14_reg  <= C_P_NEG * pres13_reg;
        pres14_reg <= pres13_reg;
        temp14_reg <= temp13_reg;
        st14_reg   <= st13_reg;

        // square is scaled before the shift
        m3_15_reg  <= m1_14_reg * C_P_MUL;
        x2_15_reg  <= asr(m2_14_reg, 16);
        pres15_reg <= pres14_reg;
        temp15_reg <= temp14_reg;
        st15_reg   <= st14_reg;

        res_reg.status <= st15_reg;
        if (st15_reg != ST_OK)
        begin
            res_reg.temperature_tenths <= '0;
            res_reg.pressure_pascal    <= '0;
        end
        else
        begin
            res_reg.temperature_tenths <= $signed(temp15_reg);
            res_reg.pressure_pascal    <= $signed(p_final);
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    // every request comes out after the fixed pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing at expected pipeline depth");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching request");

    // failed compensation gives zero values
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |->
            ((result.temperature_tenths == 0) && (result.pressure_pascal == 0)))
        else $error("non-zero values on failed compensation");
`endif

endmodule

// ----- bench/barometric_pressure_compensation_unit_tb.sv -----
// testbench for barometric_pressure_compensation_unit: drives raw readings, predicts
// each compensated result and checks it field by field; depends on bpc_pkg and the rtl
`timescale 1ns / 1ps

module barometric_pressure_compensation_unit_tb;
    import bpc_pkg::*;

    localparam int LATENCY = 73;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    req_t        request = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        done;
    res_t        result;

    // shadow of the configuration
    logic [1:0]  oss_q;
    logic [31:0] cal_q [1:5];

    res_t        pending_results [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          quiet_sender = 1'b0;

    barometric_pressure_compensation_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] sar(input logic [31:0] v, input int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic res_t compensate(input req_t r);
        res_t        res;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, den, b5, b6, b6sq, b3, b4, delta, b7, pres, t;
        longint      q;
        ac1 = sext16(cal_q[1][31:16]);
        ac2 = sext16(cal_q[1][15:0]);
        ac3 = sext16(cal_q[2][31:16]);
        ac4 = {16'd0, cal_q[2][15:0]};
        ac5 = {16'd0, cal_q[3][31:16]};
        ac6 = {16'd0, cal_q[3][15:0]};
        b1  = sext16(cal_q[4][31:16]);
        b2  = sext16(cal_q[4][15:0]);
        mc  = sext16(cal_q[5][31:16]);
        md  = sext16(cal_q[5][15:0]);
        ut  = {16'd0, r.raw_temperature};
        up  = {13'd0, r.uncomp_pressure};
        res = '0;
        res.status = ST_OK;
        x1 = sar((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0)
        begin
            res.status = ST_TDIV;
            return res;
        end
        // c-style division truncates toward zero, as does longint /
        q = (longint'($signed(mc)) * 2048) / longint'($signed(den));
        x2 = q[31:0];
        b5 = x1 + x2;
        t = sar(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        b6sq = sar(b6 * b6, 12);
        x1 = sar(b2 * b6sq, 11);
        x2 = sar(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sar(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 2);
        x1 = sar(ac3 * b6, 13);
        x2 = sar(b1 * b6sq, 16);
        x3 = sar(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0)
        begin
            res.status = ST_PDIV;
            return res;
        end
        delta = up - b3;
        if (delta == 0 || delta[31])
        begin
            res.status = ST_DELTA;
            return res;
        end
        b7 = delta * (32'd50000 >> oss_q);
        if (!b7[31])
            pres = (b7 << 1) / b4;
        else
            pres = (b7 / b4) << 1;
        x1 = sar(pres, 8);
        x1 = x1 * x1;
        x1 = sar(x1 * 32'd3038, 16);
        x2 = sar(32'hFFFF_E343 * pres, 16);
        pres = pres + sar(x1 + x2 + 32'd3791, 4);
        res.temperature_tenths = t;
        res.pressure_pascal = pres;
        return res;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (result.temperature_tenths !== exp_res.temperature_tenths)
                begin
                    $error("temperature_tenths expected %0d actual %0d",
                           exp_res.temperature_tenths, result.temperature_tenths);
                    error_count++;
                end
                if (result.pressure_pascal !== exp_res.pressure_pascal)
                begin
                    $error("pressure_pascal expected %0d actual %0d",
                           exp_res.pressure_pascal, result.pressure_pascal);
                    error_count++;
                end
                if (result.status !== exp_res.status)
                begin
                    $error("status expected %0d actual %0d", exp_res.status, result.status);
                    error_count++;
                end
            end
        end
    end

    task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
        while (!quiet_sender && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        request <= '{raw_temperature: ut, uncomp_pressure: up};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(compensate('{raw_temperature: ut, uncomp_pressure: up}));
        @(negedge clk);
    endtask

    task automatic drain_pipeline;
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_OSS)
            oss_q = value[1:0];
        else if (idx <= REG_MCMD)
            cal_q[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_calibration(input logic [1:0] oss, input logic [31:0] c1,
                                    input logic [31:0] c2, input logic [31:0] c3,
                                    input logic [31:0] c4, input logic [31:0] c5);
        drain_pipeline();
        write_register(REG_OSS, {30'd0, oss});
        write_register(REG_AC1AC2, c1);
        write_register(REG_AC3AC4, c2);
        write_register(REG_AC5AC6, c3);
        write_register(REG_B1B2, c4);
        write_register(REG_MCMD, c5);
    endtask

    // typical datasheet calibration
    task automatic load_typical(input logic [1:0] oss);
        load_calibration(oss, {16'sd408, -16'sd72}, {-16'sd14383, 16'd32741},
                         {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
                         {-16'sd8711, 16'sd2868});
    endtask

    task automatic test_reset_defaults;
        // all-zero calibration gives a zero temperature divisor
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
    endtask

    task automatic test_directed;
        load_typical(2'd0);
        send_reading(16'd27898, 19'd23843);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'hAAAA, 19'h55555);
        send_reading(16'h5555, 19'h2AAAA);
        load_typical(2'd3);
        send_reading(16'd27898, 19'd190000);
        send_reading(16'd27898, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        // zero ac4 forces a zero pressure divisor
        load_calibration(2'd1, 32'h0198_FFB8, 32'hC7D1_0000, 32'h7FF5_5A71,
                         32'h182E_0004, 32'hDDE9_0B34);
        send_reading(16'd27898, 19'd23843);
        // ac5 and ac6 at 0xFFFF, md at its largest positive value
        load_calibration(2'd2, 32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_FFFF,
                         32'h7FFF_8000, 32'h8000_7FFF);
        send_reading(16'd100, 19'd500);
        send_reading(16'hFFFF, 19'h7FFFF);
        load_calibration(2'd3, 32'h8000_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000,
                         32'h8000_7FFF, 32'h7FFF_8000);
        send_reading(16'd0, 19'h7FFFF);
        send_reading(16'hFFFF, 19'd1);
    endtask

    task automatic test_random_calibration;
        logic [31:0] c [1:5];
        for (int phase = 0; phase < 6; phase++)
        begin
            foreach (c[i])
                c[i] = $urandom;
            load_calibration(2'($urandom_range(3)), c[1], c[2], c[3], c[4], c[5]);
            for (int n = 0; n < 50; n++)
                send_reading(16'($urandom), 19'($urandom));
        end
    endtask

    task automatic test_random_typical;
        for (int phase = 0; phase < 4; phase++)
        begin
            load_typical(2'(phase));
            quiet_sender = (phase == 2);
            for (int n = 0; n < 375; n++)
            begin
                // mostly plausible readings so the pressure path is exercised
                if ($urandom_range(9) < 8)
                    send_reading(16'($urandom_range(20000, 36000)),
                                 19'($urandom_range(10000, 60000) << phase));
                else
                    send_reading(16'($urandom), 19'($urandom));
            end
            quiet_sender = 1'b0;
        end
    endtask

    initial
    begin
        oss_q = '0;
        foreach (cal_q[i])
            cal_q[i] = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_directed();
        test_random_calibration();
        test_random_typical();
        drain_pipeline();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
